[rtl/izm_pkg.sv]
// Package for the 2x bilinear zoom block: sizes, field widths, result kinds
// and the register clamp helper. No dependencies.
package izm_pkg;

    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 11;
    localparam int COORD_W = 11;
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int IDX_W   = 1;

    localparam logic [IDX_W-1:0] REG_IMAGE_COLS = 1'b0;
    localparam logic [IDX_W-1:0] REG_IMAGE_ROWS = 1'b1;

    // Order in which the results of one pixel leave the block.
    typedef enum logic [1:0] {
        KIND_COPY,
        KIND_HORZ,
        KIND_VERT,
        KIND_CNTR
    } t_kind;

    // One accepted pixel with its neighbors, handed from fetch to emit.
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] left;
        logic [PIX_W-1:0] up;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             fend;
    } t_item;

    // Clamps a written size to 2..maxv and returns the last valid index.
    function automatic logic [31:0] size_last(logic [CFG_W-1:0] v, int maxv);
        logic [31:0] eff;
        eff = 32'(v);
        if (eff < 32'd2) begin
            eff = 32'd2;
        end else if (eff > 32'(maxv)) begin
            eff = 32'(maxv);
        end
        return eff - 32'd1;
    endfunction

endpackage

[rtl/izm_ram.sv]
// Generic simple dual-port RAM with a registered, read-first read port.
// No dependencies.
module izm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read and a write to the same address in one cycle return the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/izm_fetch.sv]
// Input stage: size registers, raster counters, line store and input register.
// Depends on izm_pkg and izm_ram.
module izm_fetch
    import izm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [PIX_W-1:0] i_pixel,
    output logic             o_item_valid,
    output t_item            o_item,
    input  logic             i_item_take
);

    logic [COL_W-1:0] r_cols_last, n_cols_last;
    logic [ROW_W-1:0] r_rows_last, n_rows_last;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [PIX_W-1:0] r_left;
    logic             r_a_valid;
    logic [PIX_W-1:0] r_a_pix;
    logic [PIX_W-1:0] r_a_left;
    logic [COL_W-1:0] r_a_col;
    logic [ROW_W-1:0] r_a_row;
    logic             r_a_fend;
    logic [PIX_W-1:0] up_data;
    logic             accept;
    logic             row_end;
    logic             frame_end;

    assign o_in_ready = !r_a_valid || i_item_take;
    assign accept     = i_in_valid && o_in_ready;
    assign row_end    = (r_col >= r_cols_last);
    assign frame_end  = row_end && (r_row >= r_rows_last);

    always_comb begin
        n_cols_last = r_cols_last;
        n_rows_last = r_rows_last;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_COLS: n_cols_last = COL_W'(size_last(i_cfg_data, MAX_COLS));
                REG_IMAGE_ROWS: n_rows_last = ROW_W'(size_last(i_cfg_data, MAX_ROWS));
                default: ;
            endcase
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (row_end) begin
                n_col = '0;
                if (frame_end) begin
                    n_row = '0;
                end else if (r_row != ROW_W'(MAX_ROWS - 1)) begin
                    n_row = r_row + ROW_W'(1);
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_last <= COL_W'(MAX_COLS - 1);
            r_rows_last <= ROW_W'(MAX_ROWS - 1);
            r_col       <= '0;
            r_row       <= '0;
            r_left      <= '0;
            r_a_valid   <= 1'b0;
        end else begin
            r_cols_last <= n_cols_last;
            r_rows_last <= n_rows_last;
            r_col       <= n_col;
            r_row       <= n_row;
            if (accept) begin
                r_left    <= i_pixel;
                r_a_valid <= 1'b1;
            end else if (i_item_take) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pix  <= i_pixel;
            r_a_left <= r_left;
            r_a_col  <= r_col;
            r_a_row  <= r_row;
            r_a_fend <= frame_end;
        end
    end

    // The pixel above is read and the new pixel written in the accept cycle;
    // the read data then holds until the next beat.
    izm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_COLS)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata (i_pixel),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (up_data)
    );

    assign o_item_valid = r_a_valid;
    assign o_item.pix   = r_a_pix;
    assign o_item.left  = r_a_left;
    assign o_item.up    = up_data;
    assign o_item.row   = r_a_row;
    assign o_item.col   = r_a_col;
    assign o_item.fend  = r_a_fend;

endmodule

[rtl/izm_emit.sv]
// Result stage: forms the copy and the three rounded averages of one pixel
// and sends those that exist at its position one beat at a time. Depends on izm_pkg.
module izm_emit
    import izm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_item_valid,
    input  t_item              i_item,
    output logic               o_item_take,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [COORD_W-1:0] o_out_row,
    output logic [COORD_W-1:0] o_out_col,
    output logic [PIX_W-1:0]   o_value,
    output logic               o_last,
    output logic               o_frame_end
);

    logic               r_b_valid;
    t_kind              r_kind, n_kind;
    logic [PIX_W-1:0]   r_ul;
    logic [PIX_W-1:0]   r_v_copy, r_v_horz, r_v_vert, r_v_cntr;
    logic [COORD_W-1:0] r_r2, r_c2;
    logic               r_has_h, r_has_v;
    logic               r_fend;
    logic [PIX_W:0]     sum_h, sum_v;
    logic [PIX_W+1:0]   sum_c;
    logic [ROW_W+COORD_W:0] row_dbl;
    logic [COL_W+COORD_W:0] col_dbl;
    logic               last_cur;
    logic               out_beat;

    assign sum_h = {1'b0, i_item.left} + {1'b0, i_item.pix} + (PIX_W+1)'(1);
    assign sum_v = {1'b0, i_item.up} + {1'b0, i_item.pix} + (PIX_W+1)'(1);
    assign sum_c = {2'b00, r_ul} + {2'b00, i_item.up} + {2'b00, i_item.left}
                 + {2'b00, i_item.pix} + (PIX_W+2)'(2);
    assign row_dbl = {{COORD_W{1'b0}}, i_item.row, 1'b0};
    assign col_dbl = {{COORD_W{1'b0}}, i_item.col, 1'b0};

    always_comb begin
        case (r_kind)
            KIND_COPY: last_cur = !(r_has_h || r_has_v);
            KIND_HORZ: last_cur = !r_has_v;
            KIND_VERT: last_cur = !r_has_h;
            default:   last_cur = 1'b1;
        endcase
    end

    assign out_beat    = r_b_valid && i_out_ready;
    assign o_item_take = i_item_valid && (!r_b_valid || (i_out_ready && last_cur));

    // Only reached when more results of the same pixel follow.
    always_comb begin
        case (r_kind)
            KIND_COPY: n_kind = r_has_h ? KIND_HORZ : KIND_VERT;
            KIND_HORZ: n_kind = KIND_VERT;
            default:   n_kind = KIND_CNTR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_kind    <= KIND_COPY;
            r_ul      <= '0;
        end else begin
            if (o_item_take) begin
                r_b_valid <= 1'b1;
                r_kind    <= KIND_COPY;
                r_ul      <= i_item.up;
            end else if (out_beat) begin
                if (last_cur) begin
                    r_b_valid <= 1'b0;
                end else begin
                    r_kind <= n_kind;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_take) begin
            r_v_copy <= i_item.pix;
            r_v_horz <= sum_h[PIX_W:1];
            r_v_vert <= sum_v[PIX_W:1];
            r_v_cntr <= sum_c[PIX_W+1:2];
            r_r2     <= row_dbl[COORD_W-1:0];
            r_c2     <= col_dbl[COORD_W-1:0];
            r_has_h  <= (i_item.col != '0);
            r_has_v  <= (i_item.row != '0);
            r_fend   <= i_item.fend;
        end
    end

    always_comb begin
        case (r_kind)
            KIND_COPY: begin
                o_out_row = r_r2;
                o_out_col = r_c2;
                o_value   = r_v_copy;
            end
            KIND_HORZ: begin
                o_out_row = r_r2;
                o_out_col = r_c2 - COORD_W'(1);
                o_value   = r_v_horz;
            end
            KIND_VERT: begin
                o_out_row = r_r2 - COORD_W'(1);
                o_out_col = r_c2;
                o_value   = r_v_vert;
            end
            default: begin
                o_out_row = r_r2 - COORD_W'(1);
                o_out_col = r_c2 - COORD_W'(1);
                o_value   = r_v_cntr;
            end
        endcase
    end

    assign o_out_valid = r_b_valid;
    assign o_last      = last_cur;
    assign o_frame_end = r_fend;

endmodule

[rtl/image_zoom_2x_interpolate_top.sv]
// A pixel passes through the fetch input register and then the emit result
// register before its first result reaches the output.
// Throughput: one result beat per cycle while i_out_ready is high; a pixel gives
// 1, 2 or 4 results (4 inside the image), and the single output port sets the pace.
// Reset clears counters, sizes (1024 x 1024) and neighbors; the line store is
// not cleared and needs no pass, so pixels are accepted right after reset.
module image_zoom_2x_interpolate_top
    import izm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [PIX_W-1:0]   i_pixel,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [COORD_W-1:0] o_out_row,
    output logic [COORD_W-1:0] o_out_col,
    output logic [PIX_W-1:0]   o_value,
    output logic               o_last,
    output logic               o_frame_end
);

    logic  item_valid;
    t_item item;
    logic  item_take;

    izm_fetch u_fetch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pixel      (i_pixel),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_take  (item_take)
    );

    izm_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_take  (item_take),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_value      (o_value),
        .o_last       (o_last),
        .o_frame_end  (o_frame_end)
    );

endmodule

[verif/izm_zoom_checker.sv]
// Scoreboard for the 2x bilinear zoom block: mirrors its line store and
// neighbor registers, queues the beats each accepted pixel should cause and
// checks every result beat against them. Depends on izm_pkg.
module izm_zoom_checker
    import izm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [PIX_W-1:0]   i_pixel,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [COORD_W-1:0] i_out_row,
    input  logic [COORD_W-1:0] i_out_col,
    input  logic [PIX_W-1:0]   i_value,
    input  logic               i_last,
    input  logic               i_frame_end,
    output int                 o_mismatches,
    output int                 o_pending
);

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   value;
        logic               last;
        logic               fend;
    } t_zoom_beat;

    t_zoom_beat       zoom_q[$];
    logic [PIX_W-1:0] line_mem [MAX_COLS];
    logic [PIX_W-1:0] left_pix;
    logic [PIX_W-1:0] ul_pix;
    int               row_pos;
    int               col_pos;
    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] rows_reg;

    function automatic int eff_dim(logic [CFG_W-1:0] v, int maxv);
        if (int'(v) < 2) begin
            return 2;
        end
        if (int'(v) > maxv) begin
            return maxv;
        end
        return int'(v);
    endfunction

    // Forms the copy, horizontal, vertical and center beats of one pixel.
    function automatic void zoom_pixel(logic [PIX_W-1:0] pix);
        int               cols;
        int               rows;
        int               i;
        int               j;
        int               mem_j;
        int               n;
        logic             row_end;
        logic             fend;
        logic [PIX_W-1:0] up;
        logic [9:0]       sum;
        t_zoom_beat       beats [4];
        cols    = eff_dim(cols_reg, MAX_COLS);
        rows    = eff_dim(rows_reg, MAX_ROWS);
        i       = row_pos;
        j       = col_pos;
        row_end = (j + 1 >= cols);
        fend    = row_end && (i + 1 >= rows);
        mem_j   = (j >= MAX_COLS) ? MAX_COLS - 1 : j;
        up      = line_mem[mem_j];

        beats[0] = '{row: COORD_W'(2 * i), col: COORD_W'(2 * j), value: pix,
                     last: 1'b0, fend: fend};
        n = 1;
        if (j > 0) begin
            sum = 10'(left_pix) + 10'(pix) + 10'd1;
            beats[n] = '{row: COORD_W'(2 * i), col: COORD_W'(2 * j - 1),
                         value: sum[8:1], last: 1'b0, fend: fend};
            n = n + 1;
        end
        if (i > 0) begin
            sum = 10'(up) + 10'(pix) + 10'd1;
            beats[n] = '{row: COORD_W'(2 * i - 1), col: COORD_W'(2 * j),
                         value: sum[8:1], last: 1'b0, fend: fend};
            n = n + 1;
        end
        if (i > 0 && j > 0) begin
            sum = 10'(ul_pix) + 10'(up) + 10'(left_pix) + 10'(pix) + 10'd2;
            beats[n] = '{row: COORD_W'(2 * i - 1), col: COORD_W'(2 * j - 1),
                         value: sum[9:2], last: 1'b0, fend: fend};
            n = n + 1;
        end
        beats[n - 1].last = 1'b1;
        for (int k = 0; k < n; k++) begin
            zoom_q.push_back(beats[k]);
        end

        ul_pix          = up;
        line_mem[mem_j] = pix;
        left_pix        = pix;
        // A shrunk size takes effect as soon as a counter reaches or passes it.
        if (row_end) begin
            col_pos = 0;
            if (fend) begin
                row_pos = 0;
            end else begin
                row_pos = (i + 1 < MAX_ROWS) ? i + 1 : i;
            end
        end else begin
            col_pos = j + 1;
        end
    endfunction

    function automatic void cmp_field(string name, logic [COORD_W-1:0] want,
                                      logic [COORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_mismatches = o_mismatches + 1;
        end
    endfunction

    function automatic void check_beat();
        t_zoom_beat want;
        if (zoom_q.size() == 0) begin
            $display("%0t: result beat row %0d col %0d value %0d with nothing expected",
                     $time, i_out_row, i_out_col, i_value);
            o_mismatches = o_mismatches + 1;
            return;
        end
        want = zoom_q.pop_front();
        cmp_field("out_row", want.row, i_out_row);
        cmp_field("out_col", want.col, i_out_col);
        cmp_field("value", COORD_W'(want.value), COORD_W'(i_value));
        cmp_field("last", COORD_W'(want.last), COORD_W'(i_last));
        cmp_field("frame_end", COORD_W'(want.fend), COORD_W'(i_frame_end));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            zoom_q.delete();
            left_pix     = '0;
            ul_pix       = '0;
            row_pos      = 0;
            col_pos      = 0;
            cols_reg     = CFG_W'(MAX_COLS);
            rows_reg     = CFG_W'(MAX_ROWS);
            o_mismatches = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_IMAGE_COLS) begin
                    cols_reg = i_cfg_data;
                end else if (i_cfg_idx == REG_IMAGE_ROWS) begin
                    rows_reg = i_cfg_data;
                end
            end
            if (i_out_valid && i_out_ready) begin
                check_beat();
            end
            if (i_in_valid && i_in_ready) begin
                zoom_pixel(i_pixel);
            end
        end
        o_pending = zoom_q.size();
    end

endmodule

[verif/image_zoom_2x_interpolate_top_tb.sv]
// Testbench top for the 2x bilinear zoom block: drives pixels, size writes and
// output back-pressure, and gives the verdict. Depends on izm_pkg, the block
// and izm_zoom_checker.
module image_zoom_2x_interpolate_top_tb;
    import izm_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 80;
    localparam int HOLD_CYCLES = 300;
    localparam int N_DIRECTED  = 23;

    localparam logic [PIX_W-1:0] DIR_PIX [N_DIRECTED] = '{
        8'd0,   8'd255, 8'd128, 8'd255, 8'd255, 8'd255, 8'd0,   8'd127,
        8'd1,   8'd254, 8'd0,   8'd255, 8'd255, 8'd0,   8'd200, 8'd255,
        8'd255, 8'd0,   8'd0,   8'd255, 8'd255, 8'd128, 8'd129
    };

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx   = REG_IMAGE_COLS;
    logic [CFG_W-1:0]   i_cfg_data  = '0;
    logic               i_in_valid  = 1'b0;
    logic [PIX_W-1:0]   i_pixel     = '0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [COORD_W-1:0] o_out_row;
    logic [COORD_W-1:0] o_out_col;
    logic [PIX_W-1:0]   o_value;
    logic               o_last;
    logic               o_frame_end;

    int               mismatches;
    int               pending;
    int               send_idle_pct = 7;
    int               recv_idle_pct = 71;
    int               hold_reqs     = 0;
    int               hold_seen     = 0;
    int               hold_left     = 0;
    int               dir_k         = 0;
    logic [CFG_W-1:0] cur_cols      = CFG_W'(MAX_COLS);
    logic [CFG_W-1:0] cur_rows      = CFG_W'(MAX_ROWS);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    image_zoom_2x_interpolate_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pixel     (i_pixel),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_value     (o_value),
        .o_last      (o_last),
        .o_frame_end (o_frame_end)
    );

    izm_zoom_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_pixel      (i_pixel),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_row    (o_out_row),
        .i_out_col    (o_out_col),
        .i_value      (o_value),
        .i_last       (o_last),
        .i_frame_end  (o_frame_end),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Receiver: random stalls, or a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int eff_dim(logic [CFG_W-1:0] v, int maxv);
        if (int'(v) < 2) begin
            return 2;
        end
        if (int'(v) > maxv) begin
            return maxv;
        end
        return int'(v);
    endfunction

    // Valid is only lowered for an idle cycle, never between two back-to-back beats.
    task automatic send_pixel(input logic [PIX_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel    <= v;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_directed(input int n);
        repeat (n) begin
            send_pixel(DIR_PIX[dir_k]);
            dir_k = dir_k + 1;
        end
    endtask

    // The checker's count is sampled at the falling edge, away from its updates.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic set_size(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_IMAGE_COLS;
        i_cfg_data <= cols;
        @(posedge i_clk);
        i_cfg_idx  <= REG_IMAGE_ROWS;
        i_cfg_data <= rows;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_cols = cols;
        cur_rows = rows;
    endtask

    task automatic send_frame(output int n);
        n = eff_dim(cur_cols, MAX_COLS) * eff_dim(cur_rows, MAX_ROWS);
        repeat (n) send_pixel(PIX_W'($urandom_range(255)));
    endtask

    // Apart from the opening partial frame at a large size, sizes change only
    // at frame boundaries here, so row 0 always fills the line store before
    // any row reads it.
    task automatic run_phase(input int snd_pct, input int rcv_pct, input logic with_big,
                             input logic [CFG_W-1:0] big_cols,
                             input logic [CFG_W-1:0] big_rows, input int big_n,
                             input int tail_n, input logic with_hold);
        int               n;
        int               items;
        int               frame_no;
        logic [CFG_W-1:0] cols;
        logic [CFG_W-1:0] rows;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        items         = 0;
        frame_no      = 0;
        if (with_big) begin
            drain();
            set_size(big_cols, big_rows);
            repeat (big_n) send_pixel(PIX_W'($urandom_range(255)));
            // Shrinking to 2 x 2 closes the partial frame within a few beats.
            drain();
            set_size(CFG_W'(2), CFG_W'(2));
            repeat (tail_n) send_pixel(PIX_W'($urandom_range(255)));
        end
        while (items < PHASE_ITEMS) begin
            if (frame_no == 0 || $urandom_range(99) < 60) begin
                drain();
                if (frame_no == 0 && with_hold) begin
                    set_size(CFG_W'(8), CFG_W'(6));
                    hold_reqs <= hold_reqs + 1;
                end else begin
                    cols = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(1))
                                                    : CFG_W'($urandom_range(9, 2));
                    rows = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(1))
                                                    : CFG_W'($urandom_range(6, 2));
                    set_size(cols, rows);
                end
            end
            send_frame(n);
            items    = items + n;
            frame_no = frame_no + 1;
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Start at the reset size, then shrink the row width mid-row.
        send_directed(3);
        drain();
        set_size(CFG_W'(4), CFG_W'(2));
        send_directed(5);

        // Column count shrinks below the current column in the middle of a frame.
        drain();
        set_size(CFG_W'(4), CFG_W'(3));
        send_directed(6);
        drain();
        set_size(CFG_W'(2), CFG_W'(3));
        send_directed(3);

        // Row count drops below the current row; a value of 1 acts as 2.
        drain();
        set_size(CFG_W'(2), CFG_W'(5));
        send_directed(4);
        drain();
        set_size(CFG_W'(2), CFG_W'(1));
        send_directed(2);

        // A partial row at full width ends after one more beat and a 2-pixel row;
        // ten 2-pixel rows at an oversized height end after one more row.
        run_phase(7, 71, 1'b1, CFG_W'(MAX_COLS), CFG_W'(2), 20, 3, 1'b1);
        run_phase(71, 7, 1'b1, CFG_W'(2), CFG_W'(2047), 20, 2, 1'b0);
        run_phase(0, 0, 1'b0, CFG_W'(2), CFG_W'(2), 0, 0, 1'b1);

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
